// File: design/http_chunked_transfer_decoder_defines.svh
// Assertion macros used by the checker of the chunked decoder.
`ifndef HTTP_CHUNKED_TRANSFER_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_TRANSFER_DECODER_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define HCTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chunked decoder: implication check failed");

// Next-cycle implication, quiet while reset is asserted.
`define HCTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chunked decoder: next-cycle check failed");

`endif

// File: design/hctd_pkg.sv
`timescale 1ns / 1ps

package hctd_pkg;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    localparam logic [1:0] STATUS_BUSY  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    typedef struct packed {
        logic       consumed;
        logic       payload;
        logic [7:0] data;
        logic [1:0] status;
    } hctd_result_t;

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

// File: design/hctd_in_reg.sv
`timescale 1ns / 1ps

module hctd_in_reg
    import hctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       fire,
    output logic       in_stall,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       take;

    // Free slot, or the held byte leaves this cycle.
    assign in_stall   = valid_reg && !fire;
    assign take       = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= take || (valid_reg && !fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

// File: design/hctd_parser.sv
`timescale 1ns / 1ps

module hctd_parser
    import hctd_pkg::*;
#(
    parameter int SIZE_LINE_CAPACITY = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   byte_in,
    output hctd_result_t result
);

    localparam int CW = $clog2(SIZE_LINE_CAPACITY);
    localparam logic [CW:0] CAP = (CW + 1)'(SIZE_LINE_CAPACITY);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_CR,
        PH_LF,
        PH_TRAIL,
        PH_DONE,
        PH_ERR
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [31:0]   left_reg, left_next;
    logic [31:0]   accum_reg, accum_next;
    logic [CW-1:0] count_reg, count_next;
    logic          term_reg, term_next;
    logic          digit_reg, digit_next;
    logic          bad_reg, bad_next;
    logic          nonblank_reg, nonblank_next;

    logic [4:0]    hex;
    logic [31:0]   left_dec;
    logic          line_full;

    assign hex       = hex_digit(byte_in);
    assign left_dec  = left_reg - 32'd1;
    assign line_full = ({1'b0, count_reg} + (CW + 1)'(1)) >= CAP;

    always_comb
    begin
        phase_next      = phase_reg;
        left_next       = left_reg;
        accum_next      = accum_reg;
        count_next      = count_reg;
        term_next       = term_reg;
        digit_next      = digit_reg;
        bad_next        = bad_reg;
        nonblank_next   = nonblank_reg;
        result.consumed = 1'b1;
        result.payload  = 1'b0;
        result.data     = 8'd0;

        case (phase_reg)
            PH_SIZE:
            begin
                if (byte_in == CHAR_LF)
                begin
                    if (!digit_reg || bad_reg)
                    begin
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        left_next     = accum_reg;
                        phase_next    = (accum_reg != 32'd0) ? PH_DATA : PH_TRAIL;
                        nonblank_next = 1'b0;
                        accum_next    = 32'd0;
                        count_next    = '0;
                        term_next     = 1'b0;
                        digit_next    = 1'b0;
                        bad_next      = 1'b0;
                    end
                end
                else if (byte_in != CHAR_CR)
                begin
                    if (line_full)
                    begin
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        if (!term_reg)
                        begin
                            if (byte_in == CHAR_SEMI || byte_in == CHAR_NUL)
                            begin
                                term_next = 1'b1;
                            end
                            else
                            begin
                                digit_next = 1'b1;
                                if (!hex[4] || accum_reg[31:28] != 4'd0)
                                begin
                                    bad_next = 1'b1;
                                end
                                else
                                begin
                                    accum_next = {accum_reg[27:0], hex[3:0]};
                                end
                            end
                        end
                    end
                end
            end
            PH_DATA:
            begin
                result.payload = 1'b1;
                result.data    = byte_in;
                if (left_reg != 32'd0)
                begin
                    left_next = left_dec;
                    if (left_dec == 32'd0)
                    begin
                        phase_next = PH_CR;
                    end
                end
                else
                begin
                    phase_next = PH_CR;
                end
            end
            PH_CR:
            begin
                phase_next = (byte_in == CHAR_CR) ? PH_LF : PH_ERR;
            end
            PH_LF:
            begin
                phase_next = (byte_in == CHAR_LF) ? PH_SIZE : PH_ERR;
            end
            PH_TRAIL:
            begin
                if (byte_in == CHAR_LF)
                begin
                    if (!nonblank_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                    nonblank_next = 1'b0;
                end
                else if (byte_in != CHAR_CR)
                begin
                    nonblank_next = 1'b1;
                end
            end
            PH_DONE:
            begin
                result.consumed = 1'b0;
            end
            default:
            begin
                result.consumed = 1'b0;
                phase_next      = PH_ERR;
            end
        endcase

        case (phase_next)
            PH_DONE:  result.status = STATUS_DONE;
            PH_ERR:   result.status = STATUS_ERROR;
            default:  result.status = STATUS_BUSY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIZE;
            left_reg     <= 32'd0;
            accum_reg    <= 32'd0;
            count_reg    <= '0;
            term_reg     <= 1'b0;
            digit_reg    <= 1'b0;
            bad_reg      <= 1'b0;
            nonblank_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            accum_reg    <= accum_next;
            count_reg    <= count_next;
            term_reg     <= term_next;
            digit_reg    <= digit_next;
            bad_reg      <= bad_next;
            nonblank_reg <= nonblank_next;
        end
    end

endmodule

// File: design/hctd_out_reg.sv
`timescale 1ns / 1ps

module hctd_out_reg
    import hctd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  hctd_result_t result,
    input  logic         out_stall,
    output logic         out_valid,
    output hctd_result_t held
);

    logic         valid_reg;
    hctd_result_t result_reg;

    assign out_valid = valid_reg;
    assign held      = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= fire || (valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

endmodule

// File: design/http_chunked_transfer_decoder.sv
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid / in_stall  in_byte[7:0]
// out      out_valid/out_stall  byte_consumed, payload_valid, out_byte[7:0], status[1:0]
//
// One byte per cycle sustained while out_stall is low; the byte of an input transfer is
// held in the input register, then the parse state update writes its result into the result register.
// The rate is set by the update of the parser state once per byte.
// rst_n is asynchronous, active low; it returns the parser to the size line.
// A stall on the out channel holds the result register, then the input register
// fills and in_stall rises in the same cycle that the held byte cannot advance.

module http_chunked_transfer_decoder
    import hctd_pkg::*;
#(
    parameter int SIZE_LINE_CAPACITY = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       byte_consumed,
    output logic       payload_valid,
    output logic [7:0] out_byte,
    output logic [1:0] status
);

    logic         held_valid;
    logic [7:0]   held_byte;
    logic         fire;
    hctd_result_t step_result;
    hctd_result_t out_result;

    // Advance the held byte when the result register is empty or being drained.
    assign fire = held_valid && (!out_valid || !out_stall);

    hctd_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .fire       (fire),
        .in_stall   (in_stall),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    // Parse state lives here; it moves only on a byte that advances.
    hctd_parser #(
        .SIZE_LINE_CAPACITY (SIZE_LINE_CAPACITY)
    ) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (held_byte),
        .result  (step_result)
    );

    hctd_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .result    (step_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .held      (out_result)
    );

    assign byte_consumed = out_result.consumed;
    assign payload_valid = out_result.payload;
    assign out_byte      = out_result.data;
    assign status        = out_result.status;

endmodule

// File: design/hctd_checker.sv
`timescale 1ns / 1ps
`include "http_chunked_transfer_decoder_defines.svh"

module hctd_checker
    import hctd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       byte_consumed,
    input logic       payload_valid,
    input logic [7:0] out_byte,
    input logic [1:0] status
);

    logic        result_idle;
    logic        out_held;
    logic [11:0] out_word;
    logic        payload_ok;
    logic        idle_ok;

    assign result_idle = !byte_consumed && !payload_valid && out_byte == 8'd0;
    assign out_held    = out_valid && out_stall;
    assign out_word    = {byte_consumed, payload_valid, out_byte, status};
    assign payload_ok  = byte_consumed && (status == STATUS_BUSY || status == STATUS_ERROR);
    assign idle_ok     = result_idle && (status == STATUS_DONE || status == STATUS_ERROR);

    `HCTD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_word))
    `HCTD_ASSERT_IMPLY(a_payload_taken, clk, rst_n, out_valid && payload_valid, payload_ok)
    `HCTD_ASSERT_IMPLY(a_done_idle, clk, rst_n, out_valid && !byte_consumed, idle_ok)
    `HCTD_ASSERT_IMPLY(a_byte_zero, clk, rst_n, out_valid && !payload_valid, out_byte == 8'd0)

endmodule

bind http_chunked_transfer_decoder hctd_checker u_hctd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .byte_consumed (byte_consumed),
    .payload_valid (payload_valid),
    .out_byte      (out_byte),
    .status        (status)
);
